### hw/rtl/red_ratio_mask_centroid_macros.svh
// assertion helpers for the checker of this block
`ifndef RED_RATIO_MASK_CENTROID_MACROS_SVH
`define RED_RATIO_MASK_CENTROID_MACROS_SVH

// checked only outside reset
`define RRMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define RRMC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/rrmc_pkg.sv
`default_nettype none

package rrmc_pkg;

  localparam int unsigned MaxCols    = 2048;
  localparam int unsigned MaxRows    = 2048;

  localparam int unsigned PixW       = 8;
  localparam int unsigned CoordW     = 11;
  localparam int unsigned CountW     = 23;
  localparam int unsigned SumW       = 34;
  localparam int unsigned ThreshW    = 8;
  localparam int unsigned QuotW      = CoordW;
  localparam int unsigned DivStepW   = $clog2(QuotW);

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;

  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(10);
  localparam logic [CountW-1:0]  CountMax    = '1;
  localparam logic [CoordW-1:0]  ColLimit    = CoordW'(MaxCols - 1);
  localparam logic [CoordW-1:0]  RowLimit    = CoordW'(MaxRows - 1);

  typedef enum logic [0:0] {
    RegThreshold = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    BackAcc = 2'd0,
    BackDiv = 2'd1,
    BackOut = 2'd2
  } back_state_e;

  typedef struct packed {
    logic              mask_bit;
    logic              frame_last;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } queue_entry_t;

endpackage

`default_nettype wire

### hw/rtl/rrmc_if.sv
`default_nettype none

interface rrmc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_blue;
  logic [7:0] pixel_green;
  logic [7:0] pixel_red;
  logic [10:0] pixel_col;
  logic [10:0] pixel_row;
  logic       frame_last;

  modport source (output valid, pixel_blue, pixel_green, pixel_red, pixel_col,
                  pixel_row, frame_last, input ready);
  modport sink (input valid, pixel_blue, pixel_green, pixel_red, pixel_col,
                pixel_row, frame_last, output ready);
endinterface

interface rrmc_res_if;
  logic        valid;
  logic        ready;
  logic        mask_bit;
  logic        frame_done;
  logic        blob_found;
  logic [10:0] centroid_col;
  logic [10:0] centroid_row;
  logic [22:0] marked_count;

  modport source (output valid, mask_bit, frame_done, blob_found, centroid_col,
                  centroid_row, marked_count, input ready);
  modport sink (input valid, mask_bit, frame_done, blob_found, centroid_col,
                centroid_row, marked_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/rrmc_front.sv
`default_nettype none

module rrmc_front (
  rrmc_pix_if.sink                     pix_i,
  input  logic [rrmc_pkg::ThreshW-1:0] threshold_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output rrmc_pkg::queue_entry_t       entry_o
);

  // floor((r+1)/d) > t  <=>  r+1 >= (t+1)*d
  logic [8:0]  red_inc;
  logic [9:0]  divisor;
  logic [8:0]  thr_inc;
  logic [18:0] limit;

  assign red_inc = {1'b0, pix_i.pixel_red} + 9'd1;
  assign divisor = {2'b00, pix_i.pixel_blue} + {2'b00, pix_i.pixel_green} + 10'd2;
  assign thr_inc = {1'b0, threshold_i} + 9'd1;
  assign limit   = {10'b0, thr_inc} * {9'b0, divisor};

  assign pix_i.ready = !q_full_i;
  assign push_o      = pix_i.valid && !q_full_i;

  always_comb begin
    entry_o.mask_bit   = {10'b0, red_inc} >= limit;
    entry_o.frame_last = pix_i.frame_last;
    entry_o.col = (32'(pix_i.pixel_col) >= rrmc_pkg::MaxCols) ? rrmc_pkg::ColLimit
                                                               : pix_i.pixel_col;
    entry_o.row = (32'(pix_i.pixel_row) >= rrmc_pkg::MaxRows) ? rrmc_pkg::RowLimit
                                                               : pix_i.pixel_row;
  end

endmodule

`default_nettype wire

### hw/rtl/rrmc_fifo.sv
`default_nettype none

module rrmc_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  rrmc_pkg::queue_entry_t entry_i,
  input  logic                   pop_i,
  output logic                   full_o,
  output logic                   empty_o,
  output rrmc_pkg::queue_entry_t entry_o
);

  localparam logic [rrmc_pkg::QPtrW-1:0] LastPtr = rrmc_pkg::QPtrW'(rrmc_pkg::QueueDepth - 1);
  localparam logic [rrmc_pkg::QCntW-1:0] FullCnt = rrmc_pkg::QCntW'(rrmc_pkg::QueueDepth);

  rrmc_pkg::queue_entry_t           mem_q [rrmc_pkg::QueueDepth];
  logic [rrmc_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rrmc_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rrmc_pkg::QCntW-1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q == FullCnt;
  assign empty_o = cnt_q == '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rrmc_back.sv
`default_nettype none

module rrmc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  rrmc_pkg::queue_entry_t entry_i,
  output logic                   pop_o,
  rrmc_res_if.source             res_o
);

  localparam int unsigned CountW = rrmc_pkg::CountW;
  localparam int unsigned SumW   = rrmc_pkg::SumW;
  localparam int unsigned QuotW  = rrmc_pkg::QuotW;
  localparam int unsigned CoordW = rrmc_pkg::CoordW;
  localparam int unsigned StepW  = rrmc_pkg::DivStepW;

  rrmc_pkg::back_state_e state_q, state_d;

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0]   col_sum_q, col_sum_d;
  logic [SumW-1:0]   row_sum_q, row_sum_d;

  logic [SumW-1:0]   rem_col_q, rem_col_d;
  logic [SumW-1:0]   rem_row_q, rem_row_d;
  logic [SumW-1:0]   div_sh_q, div_sh_d;
  logic [QuotW-1:0]  quo_col_q, quo_col_d;
  logic [QuotW-1:0]  quo_row_q, quo_row_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CountW-1:0] fin_count_q, fin_count_d;
  logic              fin_mask_q, fin_mask_d;

  logic              out_valid_q, out_valid_d;
  logic              out_mask_q, out_mask_d;
  logic              out_done_q, out_done_d;
  logic              out_found_q, out_found_d;
  logic [CoordW-1:0] out_col_q, out_col_d;
  logic [CoordW-1:0] out_row_q, out_row_d;
  logic [CountW-1:0] out_count_q, out_count_d;

  logic              out_free;
  logic              add;
  logic [CountW-1:0] cnt_inc;
  logic [SumW-1:0]   col_sum_inc;
  logic [SumW-1:0]   row_sum_inc;
  logic              ge_col, ge_row;
  logic              found;

  assign out_free = !out_valid_q || res_o.ready;

  // counter saturates, sums freeze with it
  assign add         = entry_i.mask_bit && (cnt_q != rrmc_pkg::CountMax);
  assign cnt_inc     = add ? cnt_q + 1'b1 : cnt_q;
  assign col_sum_inc = add ? col_sum_q + SumW'(entry_i.col) : col_sum_q;
  assign row_sum_inc = add ? row_sum_q + SumW'(entry_i.row) : row_sum_q;

  assign ge_col = rem_col_q >= div_sh_q;
  assign ge_row = rem_row_q >= div_sh_q;
  assign found  = fin_count_q != '0;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_sum_d   = col_sum_q;
    row_sum_d   = row_sum_q;
    rem_col_d   = rem_col_q;
    rem_row_d   = rem_row_q;
    div_sh_d    = div_sh_q;
    quo_col_d   = quo_col_q;
    quo_row_d   = quo_row_q;
    step_d      = step_q;
    fin_count_d = fin_count_q;
    fin_mask_d  = fin_mask_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_mask_d  = out_mask_q;
    out_done_d  = out_done_q;
    out_found_d = out_found_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_count_d = out_count_q;
    pop_o       = 1'b0;

    case (state_q)
      rrmc_pkg::BackAcc: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          if (entry_i.frame_last) begin
            // quotient fits QuotW bits, so start the divisor at the top bit
            rem_col_d   = col_sum_inc;
            rem_row_d   = row_sum_inc;
            div_sh_d    = SumW'(cnt_inc) << (QuotW - 1);
            quo_col_d   = '0;
            quo_row_d   = '0;
            step_d      = StepW'(QuotW - 1);
            fin_count_d = cnt_inc;
            fin_mask_d  = entry_i.mask_bit;
            cnt_d       = '0;
            col_sum_d   = '0;
            row_sum_d   = '0;
            state_d     = rrmc_pkg::BackDiv;
          end else begin
            cnt_d       = cnt_inc;
            col_sum_d   = col_sum_inc;
            row_sum_d   = row_sum_inc;
            out_valid_d = 1'b1;
            out_mask_d  = entry_i.mask_bit;
            out_done_d  = 1'b0;
            out_found_d = 1'b0;
            out_col_d   = '0;
            out_row_d   = '0;
            out_count_d = '0;
          end
        end
      end
      rrmc_pkg::BackDiv: begin
        if (ge_col) begin
          rem_col_d = rem_col_q - div_sh_q;
        end
        if (ge_row) begin
          rem_row_d = rem_row_q - div_sh_q;
        end
        quo_col_d = {quo_col_q[QuotW-2:0], ge_col};
        quo_row_d = {quo_row_q[QuotW-2:0], ge_row};
        div_sh_d  = div_sh_q >> 1;
        step_d    = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = rrmc_pkg::BackOut;
        end
      end
      rrmc_pkg::BackOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mask_d  = fin_mask_q;
          out_done_d  = 1'b1;
          out_found_d = found;
          out_col_d   = found ? quo_col_q : '0;
          out_row_d   = found ? quo_row_q : '0;
          out_count_d = fin_count_q;
          state_d     = rrmc_pkg::BackAcc;
        end
      end
      default: begin
        state_d = rrmc_pkg::BackAcc;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrmc_pkg::BackAcc;
      cnt_q       <= '0;
      col_sum_q   <= '0;
      row_sum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_sum_q   <= col_sum_d;
      row_sum_q   <= row_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_col_q   <= rem_col_d;
    rem_row_q   <= rem_row_d;
    div_sh_q    <= div_sh_d;
    quo_col_q   <= quo_col_d;
    quo_row_q   <= quo_row_d;
    step_q      <= step_d;
    fin_count_q <= fin_count_d;
    fin_mask_q  <= fin_mask_d;
    out_mask_q  <= out_mask_d;
    out_done_q  <= out_done_d;
    out_found_q <= out_found_d;
    out_col_q   <= out_col_d;
    out_row_q   <= out_row_d;
    out_count_q <= out_count_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.mask_bit     = out_mask_q;
  assign res_o.frame_done   = out_done_q;
  assign res_o.blob_found   = out_found_q;
  assign res_o.centroid_col = out_col_q;
  assign res_o.centroid_row = out_row_q;
  assign res_o.marked_count = out_count_q;

endmodule

`default_nettype wire

### hw/rtl/red_ratio_mask_centroid.sv
// red-ratio pixel classifier with per-frame blob centroid
//
// pix_i: one beat per BGR pixel with its column, row and a last-of-frame flag.
// res_o: exactly one beat per pixel, in order: the mask bit, and on the frame's
//   last pixel also the marked count, found flag and truncated centroid.
// apb port: one register, red_ratio_threshold at byte address 0 (reset 10);
//   write only while the block is idle.
// path: an ordinary pixel passes through the queue and then the output register;
//   a last-of-frame pixel also waits for the 11-step shared restoring divider
//   that forms column and row means side by side.
// throughput: 1 pixel per cycle inside a frame while result beats are taken; a
//   frame end holds the back end through the divide while the 4-entry queue keeps taking pixels.
// reset: threshold returns to 10, count and sums clear, queue empties, no
//   result beat is pending.
// stall: a result beat waits in the output register and the back end stops
//   popping; the queue fills and pix_i.ready drops once it holds 4 beats
`default_nettype none

module red_ratio_mask_centroid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rrmc_pix_if.sink                      pix_i,
  rrmc_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrmc_pkg::PaddrW-1:0]   paddr,
  input  logic [rrmc_pkg::PdataW-1:0]   pwdata,
  output logic [rrmc_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  logic [rrmc_pkg::ThreshW-1:0] thr_q, thr_d;
  rrmc_pkg::reg_idx_e           reg_idx;
  logic                         wr_en;

  logic                         q_full;
  logic                         q_empty;
  logic                         push;
  logic                         pop;
  rrmc_pkg::queue_entry_t       push_entry;
  rrmc_pkg::queue_entry_t       head_entry;

  // ---------------------------------------------------------------------------
  // config register, word addressed
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = rrmc_pkg::reg_idx_e'(paddr[rrmc_pkg::PaddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    thr_d  = thr_q;
    prdata = '0;
    case (reg_idx)
      rrmc_pkg::RegThreshold: begin
        prdata = rrmc_pkg::PdataW'(thr_q);
        if (wr_en) begin
          thr_d = pwdata[rrmc_pkg::ThreshW-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rrmc_pkg::ThreshReset;
    end else begin
      thr_q <= thr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // front: classify and clamp each pixel beat, push into the queue
  // ---------------------------------------------------------------------------
  rrmc_front u_front (
    .pix_i       (pix_i),
    .threshold_i (thr_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // short queue decouples the per-pixel front from the frame-end divide
  rrmc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .entry_o (head_entry)
  );

  // ---------------------------------------------------------------------------
  // back: accumulate, divide at frame end, drive the result register
  // ---------------------------------------------------------------------------
  rrmc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .entry_i (head_entry),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

### hw/rtl/rrmc_checker.sv
`default_nettype none
`include "red_ratio_mask_centroid_macros.svh"

module rrmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        res_mask_bit_i,
  input logic        res_frame_done_i,
  input logic        res_blob_found_i,
  input logic [10:0] res_centroid_col_i,
  input logic [10:0] res_centroid_row_i,
  input logic [22:0] res_marked_count_i
);

  `RRMC_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_mask_bit_i) && $stable(res_frame_done_i) && $stable(res_marked_count_i), "result beat changed while stalled")
  `RRMC_ASSERT(a_mid_frame_zero, res_valid_i && !res_frame_done_i |-> !res_blob_found_i && res_marked_count_i == 0 && res_centroid_col_i == 0 && res_centroid_row_i == 0, "frame fields set before frame end")
  `RRMC_ASSERT(a_found_count, res_valid_i && res_frame_done_i |-> res_blob_found_i == (res_marked_count_i != 0), "found flag disagrees with count")
  `RRMC_ASSERT(a_empty_centroid, res_valid_i && res_frame_done_i && !res_blob_found_i |-> res_centroid_col_i == 0 && res_centroid_row_i == 0, "centroid set with no blob")
  `RRMC_ASSERT_RST(a_reset_quiet, !rst_ni |-> !res_valid_i, "result beat offered in reset")

endmodule

bind red_ratio_mask_centroid rrmc_checker u_rrmc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_mask_bit_i     (res_o.mask_bit),
  .res_frame_done_i   (res_o.frame_done),
  .res_blob_found_i   (res_o.blob_found),
  .res_centroid_col_i (res_o.centroid_col),
  .res_centroid_row_i (res_o.centroid_row),
  .res_marked_count_i (res_o.marked_count)
);

`default_nettype wire
